// ===== hw/rtl/psd_pkg.sv =====
// psd_pkg: shared constants for point_segment_distance.
// No dependencies.
package psd_pkg;
   localparam int DIST_BITS = 25;
   localparam logic [1:0] REGION_START = 2'd0;
   localparam logic [1:0] REGION_INNER = 2'd1;
   localparam logic [1:0] REGION_END   = 2'd2;
endpackage

// ===== hw/rtl/psd_front.sv =====
// psd_front: difference vectors, dot/cross/length products and region pick.
// Depends on psd_pkg.
module psd_front import psd_pkg::*; #(
   parameter int CB = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [CB-1:0]       px, py, sx, sy, ex, ey,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [4*CB+1:0]     num,     // numerator before scaling
   output logic [2*CB+1:0]     den,     // divisor (len_sq) or 1
   output logic [1:0]          region
);
   localparam int DW = CB + 1;
   localparam int PW = 2 * DW + 1;

   // stage 1: differences
   logic               v1_ff;
   logic signed [DW-1:0] ax_ff, ay_ff, cx_ff, cy_ff, bx_ff, by_ff;
   // stage 2: products
   logic               v2_ff;
   logic signed [PW-1:0] dot_ff, crs_ff;
   logic [PW-1:0]      len_ff, a2_ff, b2_ff;
   // stage 3: region and numerator
   logic               v3_ff;
   logic [4*CB+1:0]    num_ff;
   logic [2*CB+1:0]    den_ff;
   logic [1:0]         reg_ff;

   logic adv3, adv2, adv1;
   assign adv3 = !v3_ff || out_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign in_ready = adv1;

   function automatic logic signed [DW-1:0] sx_f(input logic [CB-1:0] v);
      return DW'(signed'(v));
   endfunction

   logic [PW-1:0] cmag;
   logic          neg_dot, past_end;
   assign cmag = crs_ff[PW-1] ? PW'(-crs_ff) : PW'(crs_ff);
   assign neg_dot = dot_ff[PW-1];
   assign past_end = !neg_dot && (dot_ff > signed'({1'b0, len_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
      if (adv1) begin
         ax_ff <= sx_f(px) - sx_f(sx);
         ay_ff <= sx_f(py) - sx_f(sy);
         cx_ff <= sx_f(ex) - sx_f(sx);
         cy_ff <= sx_f(ey) - sx_f(sy);
         bx_ff <= sx_f(px) - sx_f(ex);
         by_ff <= sx_f(py) - sx_f(ey);
      end
      if (adv2) begin
         dot_ff <= PW'(ax_ff * cx_ff) + PW'(ay_ff * cy_ff);
         crs_ff <= PW'(ax_ff * cy_ff) - PW'(ay_ff * cx_ff);
         len_ff <= PW'(unsigned'(PW'(cx_ff * cx_ff))) + PW'(unsigned'(PW'(cy_ff * cy_ff)));
         a2_ff  <= PW'(unsigned'(PW'(ax_ff * ax_ff))) + PW'(unsigned'(PW'(ay_ff * ay_ff)));
         b2_ff  <= PW'(unsigned'(PW'(bx_ff * bx_ff))) + PW'(unsigned'(PW'(by_ff * by_ff)));
      end
      if (adv3) begin
         if (len_ff == '0 || neg_dot) begin
            reg_ff <= REGION_START;
            num_ff <= (4*CB+2)'(a2_ff);
            den_ff <= (2*CB+2)'(1);
         end else if (past_end) begin
            reg_ff <= REGION_END;
            num_ff <= (4*CB+2)'(b2_ff);
            den_ff <= (2*CB+2)'(1);
         end else begin
            reg_ff <= REGION_INNER;
            num_ff <= (4*CB+2)'(cmag * cmag);
            den_ff <= (2*CB+2)'(len_ff);
         end
      end
   end

   assign out_valid = v3_ff;
   assign num = num_ff;
   assign den = den_ff;
   assign region = reg_ff;
endmodule

// ===== hw/rtl/psd_fifo.sv =====
// psd_fifo: small decoupling queue between front and back.
// No package dependencies.
module psd_fifo #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   logic [W-1:0] mem_ff [4];
   logic [1:0]   wp_ff, rp_ff;
   logic [2:0]   cnt_ff;
   logic         wr, rd;
   assign in_ready  = cnt_ff != 3'd4;
   assign out_valid = cnt_ff != 3'd0;
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   assign out_data = mem_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 2'd1;
         if (rd) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, wr} - {2'd0, rd};
      end
      if (wr) mem_ff[wp_ff] <= in_data;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 3'd4)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 3'd0) |-> !rd) else $error("read from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (wr && !rd) |=> cnt_ff == $past(cnt_ff) + 3'd1) else $error("count slip");
endmodule

// ===== hw/rtl/psd_back.sv =====
// psd_back: pipelined restoring divider, one quotient bit per stage, then a
// pipelined square root, one root bit per stage. Depends on psd_pkg.
module psd_back import psd_pkg::*; #(
   parameter int CB = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [4*CB+1:0]   num,
   input  logic [2*CB+1:0]   den,
   input  logic [1:0]        region_in,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DIST_BITS-1:0] distance,
   output logic [1:0]        region
);
   localparam int NW = 4 * CB + 18;      // scaled numerator / quotient width
   localparam int DV = 2 * CB + 2;
   localparam int SQ = (NW + 1) / 2;     // root bits
   localparam int XW = 2 * SQ;

   logic stall;
   assign stall = 1'b0;

   // divider pipeline: NW stages
   logic            dv_ff [NW+1];
   logic [NW-1:0]   dq_ff [NW+1];   // numerator shifting into quotient
   logic [DV:0]     dr_ff [NW+1];
   logic [DV-1:0]   dd_ff [NW+1];
   logic [1:0]      drg_ff [NW+1];
   // root pipeline: SQ stages
   logic            sv_ff [SQ+1];
   logic [XW-1:0]   sx_ff [SQ+1];
   logic [SQ-1:0]   sr_ff [SQ+1];
   logic [SQ+1:0]   srm_ff [SQ+1];
   logic [1:0]      srg_ff [SQ+1];

   // output register with one-entry skid
   logic                 ov_ff, sk_ff;
   logic [DIST_BITS-1:0] od_ff, skd_ff;
   logic [1:0]           or_ff, skr_ff;
   logic                 go;
   assign go = !sk_ff;
   assign in_ready = go;

   always_comb dv_ff[0] = in_valid && go;
   always_comb dq_ff[0] = {num, 16'd0};
   always_comb dr_ff[0] = '0;
   always_comb dd_ff[0] = den;
   always_comb drg_ff[0] = region_in;

   for (genvar i = 0; i < NW; i++) begin : g_div
      logic [DV:0] t, s;
      assign t = {dr_ff[i][DV-1:0], dq_ff[i][NW-1]};
      assign s = t - {1'b0, dd_ff[i]};
      always_ff @(posedge clock) begin
         if (reset) dv_ff[i+1] <= 1'b0;
         else if (go) dv_ff[i+1] <= dv_ff[i];
         if (go) begin
            dd_ff[i+1] <= dd_ff[i];
            drg_ff[i+1] <= drg_ff[i];
            if (!s[DV]) begin
               dr_ff[i+1] <= s;
               dq_ff[i+1] <= {dq_ff[i][NW-2:0], 1'b1};
            end else begin
               dr_ff[i+1] <= t;
               dq_ff[i+1] <= {dq_ff[i][NW-2:0], 1'b0};
            end
         end
      end
   end

   always_comb sv_ff[0] = dv_ff[NW];
   always_comb sx_ff[0] = XW'(dq_ff[NW]);
   always_comb sr_ff[0] = '0;
   always_comb srm_ff[0] = '0;
   always_comb srg_ff[0] = drg_ff[NW];

   // digit-by-digit root: remainder srm, root sr, two radicand bits per stage
   for (genvar j = 0; j < SQ; j++) begin : g_sqrt
      logic [SQ+1:0] t, c;
      assign t = {srm_ff[j][SQ-1:0], sx_ff[j][XW-1:XW-2]};
      assign c = {sr_ff[j], 2'b01};
      always_ff @(posedge clock) begin
         if (reset) sv_ff[j+1] <= 1'b0;
         else if (go) sv_ff[j+1] <= sv_ff[j];
         if (go) begin
            srg_ff[j+1] <= srg_ff[j];
            sx_ff[j+1] <= {sx_ff[j][XW-3:0], 2'b00};
            if (t >= c) begin
               srm_ff[j+1] <= t - c;
               sr_ff[j+1] <= {sr_ff[j][SQ-2:0], 1'b1};
            end else begin
               srm_ff[j+1] <= t;
               sr_ff[j+1] <= {sr_ff[j][SQ-2:0], 1'b0};
            end
         end
      end
   end

   logic [DIST_BITS-1:0] sat;
   assign sat = (sr_ff[SQ] > SQ'({DIST_BITS{1'b1}})) ? '1 : DIST_BITS'(sr_ff[SQ]);

   // pipeline advances only when skid is empty; skid catches the item that
   // leaves the pipe while the output is blocked.
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
         sk_ff <= 1'b0;
      end else begin
         if (!ov_ff || out_ready) begin
            if (sk_ff) begin
               ov_ff <= 1'b1;
               sk_ff <= 1'b0;
            end else begin
               ov_ff <= sv_ff[SQ];
            end
         end else if (sv_ff[SQ] && go) begin
            sk_ff <= 1'b1;
         end
      end
      if (!ov_ff || out_ready) begin
         od_ff <= sk_ff ? skd_ff : sat;
         or_ff <= sk_ff ? skr_ff : srg_ff[SQ];
      end else if (go) begin
         skd_ff <= sat;
         skr_ff <= srg_ff[SQ];
      end
   end

   assign out_valid = ov_ff;
   assign distance = od_ff;
   assign region = or_ff;

   assert property (@(posedge clock) disable iff (reset | stall)
      (ov_ff && !out_ready) |=> ov_ff) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      sk_ff |-> ov_ff) else $error("skid full without output");
   assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> (or_ff != 2'd3)) else $error("bad region");
endmodule

// ===== hw/rtl/point_segment_distance.sv =====
// point_segment_distance: top level, front (products, region) -> queue ->
// back (divider, square root). Depends on psd_pkg, psd_front, psd_fifo, psd_back.
//
// Distance from a point to a 2-D segment, floor(distance * 256), with the
// closest feature in rsp_region (0 first endpoint or zero-length segment,
// 1 interior, 2 second endpoint). One request per cycle is accepted at full
// rate while rsp_ready keeps the output draining. A request passes the front's
// difference, product and region stages, the queue, 4*COORD_BITS+18 divider
// stages (one quotient bit each) and 2*COORD_BITS+9 root stages (one bit each),
// then an output register. The back pipeline stalls as a whole while its
// output skid holds a result; the four-entry queue absorbs the front's
// in-flight requests meanwhile.
module point_segment_distance import psd_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_point_x,
   input  logic [COORD_BITS-1:0] req_point_y,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DIST_BITS-1:0]  rsp_distance_q8,
   output logic [1:0]            rsp_region
);
   localparam int QW = 4 * COORD_BITS + 2 + 2 * COORD_BITS + 2 + 2;

   logic                    f_valid, f_ready, b_valid, b_ready;
   logic [4*COORD_BITS+1:0] f_num, b_num;
   logic [2*COORD_BITS+1:0] f_den, b_den;
   logic [1:0]              f_reg, b_reg;

   psd_front #(.CB(COORD_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready),
      .px(req_point_x), .py(req_point_y), .sx(req_start_x), .sy(req_start_y),
      .ex(req_end_x), .ey(req_end_y),
      .out_valid(f_valid), .out_ready(f_ready),
      .num(f_num), .den(f_den), .region(f_reg)
   );

   psd_fifo #(.W(QW)) u_fifo (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data({f_num, f_den, f_reg}),
      .out_valid(b_valid), .out_ready(b_ready), .out_data({b_num, b_den, b_reg})
   );

   psd_back #(.CB(COORD_BITS)) u_back (
      .clock, .reset,
      .in_valid(b_valid), .in_ready(b_ready),
      .num(b_num), .den(b_den), .region_in(b_reg),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .distance(rsp_distance_q8), .region(rsp_region)
   );
endmodule
